>>> rtl/mpm_pkg.sv
`default_nettype none
package mpm_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int DIV_BITS      = 48;
    localparam int DIV_STAGES    = 12;
    localparam int DIV_STEP      = DIV_BITS / DIV_STAGES;

    localparam logic [2:0] CFG_GRAVITY = 3'd0;
    localparam logic [2:0] CFG_WALL    = 3'd1;
    localparam logic [2:0] CFG_MIN_X   = 3'd2;
    localparam logic [2:0] CFG_MIN_Y   = 3'd3;
    localparam logic [2:0] CFG_MIN_Z   = 3'd4;
    localparam logic [2:0] CFG_MAX_X   = 3'd5;
    localparam logic [2:0] CFG_MAX_Y   = 3'd6;
    localparam logic [2:0] CFG_MAX_Z   = 3'd7;

    typedef struct packed {
        logic [5:0]         node_i;
        logic [5:0]         node_j;
        logic [5:0]         node_k;
        logic signed [31:0] momentum_x;
        logic signed [31:0] momentum_y;
        logic signed [31:0] momentum_z;
        logic [31:0]        node_mass;
    } node_in_t;

    typedef struct packed {
        logic               node_active;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } node_out_t;

    typedef struct packed {
        logic [15:0] gravity_step;
        logic [3:0]  wall_thickness;
        logic [14:0] box_min_x;
        logic [14:0] box_min_y;
        logic [14:0] box_min_z;
        logic [14:0] box_max_x;
        logic [14:0] box_max_y;
        logic [14:0] box_max_z;
    } cfg_t;

    typedef struct packed {
        logic [5:0] node_i;
        logic [5:0] node_j;
        logic [5:0] node_k;
        logic       active;
    } side_t;

endpackage
`default_nettype wire

>>> rtl/mpm_div.sv
`default_nettype none
// pipelined restoring divider, magnitude 48 by 32, DIV_STEP quotient bits per stage
module mpm_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [47:0] dividend,
    input  wire logic [31:0] divisor,
    output logic      [47:0] quotient
);
    import mpm_pkg::*;

    logic [47:0] q_reg  [DIV_STAGES];
    logic [32:0] r_reg  [DIV_STAGES-1];
    logic [31:0] d_reg  [DIV_STAGES-1];
    logic [47:0] q_in   [DIV_STAGES];
    logic [32:0] r_in   [DIV_STAGES];
    logic [31:0] d_in   [DIV_STAGES];
    logic [47:0] q_next [DIV_STAGES];
    logic [32:0] r_next [DIV_STAGES];

    always_comb
    begin
        q_in[0] = dividend;
        r_in[0] = '0;
        d_in[0] = divisor;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            q_in[s] = q_reg[s-1];
            r_in[s] = r_reg[s-1];
            d_in[s] = d_reg[s-1];
        end
    end

    always_comb
    begin
        logic [47:0] q;
        logic [32:0] r;
        logic [33:0] t;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            q = q_in[s];
            r = r_in[s];
            for (int b = 0; b < DIV_STEP; b++)
            begin
                t = {r, q[47]} - {2'b0, d_in[s]};
                if (!t[33])
                    r = t[32:0];
                else
                    r = {r[31:0], q[47]};
                q = {q[46:0], ~t[33]};
            end
            q_next[s] = q;
            r_next[s] = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
                q_reg[s] <= q_next[s];
            for (int s = 0; s < DIV_STAGES - 1; s++)
            begin
                r_reg[s] <= r_next[s];
                d_reg[s] <= d_in[s];
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/mpm_bc.sv
`default_nettype none
// velocity finish: sign, saturate, gravity, walls, box collision (3 stages)
module mpm_bc #(
    parameter int GRID_SIZE = mpm_pkg::GRID_SIZE_DEF
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire mpm_pkg::cfg_t    cfg,
    input  wire mpm_pkg::side_t   side,
    input  wire logic [2:0]       neg,
    input  wire logic [47:0]      qx,
    input  wire logic [47:0]      qy,
    input  wire logic [47:0]      qz,
    output mpm_pkg::node_out_t    result
);
    import mpm_pkg::*;

    logic signed [31:0] v1_reg [3];
    side_t              s1_reg, s2_reg, s3_reg;
    logic signed [31:0] v2_reg [3];
    logic [2:0]         in_reg;
    logic [16:0]        dist_reg [6];
    logic signed [31:0] v3_reg [3];

    function automatic logic signed [31:0] sat_q(input logic [47:0] q, input logic n);
        logic signed [49:0] s;
        begin
            s = n ? -$signed({2'b0, q}) : $signed({2'b0, q});
            if (s > 50'sd2147483647)
                sat_q = 32'sh7fffffff;
            else if (s < -50'sd2147483648)
                sat_q = 32'sh80000000;
            else
                sat_q = s[31:0];
        end
    endfunction

    logic signed [31:0] v1_next [3];
    always_comb
    begin
        logic signed [32:0] gy;
        v1_next[0] = sat_q(qx, neg[0]);
        v1_next[1] = sat_q(qy, neg[1]);
        v1_next[2] = sat_q(qz, neg[2]);
        gy = 33'(v1_next[1]) - $signed({17'b0, cfg.gravity_step});
        if (gy < -33'sd2147483648)
            v1_next[1] = 32'sh80000000;
        else
            v1_next[1] = gy[31:0];
    end

    logic signed [31:0] v2_next [3];
    logic [2:0]         in_next;
    logic [16:0]        dist_next [6];
    always_comb
    begin
        logic [5:0]         idx [3];
        logic signed [11:0] hi;
        logic [14:0]        mn [3];
        logic [14:0]        mx [3];
        logic [16:0]        pos;
        idx[0] = s1_reg.node_i;
        idx[1] = s1_reg.node_j;
        idx[2] = s1_reg.node_k;
        mn[0] = cfg.box_min_x; mn[1] = cfg.box_min_y; mn[2] = cfg.box_min_z;
        mx[0] = cfg.box_max_x; mx[1] = cfg.box_max_y; mx[2] = cfg.box_max_z;
        hi = 12'(GRID_SIZE) - {8'b0, cfg.wall_thickness};
        for (int a = 0; a < 3; a++)
        begin
            v2_next[a] = v1_reg[a];
            if (idx[a] < {2'b0, cfg.wall_thickness} && v1_reg[a] < 0)
                v2_next[a] = '0;
            if ($signed({6'b0, idx[a]}) > hi && v1_reg[a] > 0)
                v2_next[a] = '0;
            pos = {3'b0, idx[a], 8'b0};
            in_next[a] = (pos > {2'b0, mn[a]}) && (pos < {2'b0, mx[a]});
            dist_next[2*a]   = pos - {2'b0, mn[a]};
            dist_next[2*a+1] = {2'b0, mx[a]} - pos;
        end
    end

    logic signed [31:0] v3_next [3];
    always_comb
    begin
        logic [16:0]        best;
        logic [2:0]         face;
        logic signed [31:0] vn;
        best = dist_reg[0];
        face = 3'd0;
        for (int f = 1; f < 6; f++)
        begin
            if (dist_reg[f] < best)
            begin
                best = dist_reg[f];
                face = 3'(f);
            end
        end
        for (int a = 0; a < 3; a++)
            v3_next[a] = v2_reg[a];
        vn = v2_reg[face[2:1]];
        if (&in_reg && (face[0] ? (vn < 0) : (vn > 0)))
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (2'(a) == face[2:1])
                    v3_next[a] = '0;
                else
                    v3_next[a] = v2_reg[a] / 2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= side;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            in_reg <= in_next;
            for (int a = 0; a < 3; a++)
            begin
                v1_reg[a] <= v1_next[a];
                v2_reg[a] <= v2_next[a];
                v3_reg[a] <= v3_next[a];
            end
            for (int f = 0; f < 6; f++)
                dist_reg[f] <= dist_next[f];
        end
    end

    always_comb
    begin
        result.node_active = s3_reg.active;
        result.vel_x       = s3_reg.active ? v3_reg[0] : '0;
        result.vel_y       = s3_reg.active ? v3_reg[1] : '0;
        result.vel_z       = s3_reg.active ? v3_reg[2] : '0;
    end

endmodule
`default_nettype wire

>>> rtl/mpm_grid_node_update.sv
`default_nettype none
// Pipeline: 16 register stages (12 divider, 3 finish, output register).
// Throughput: one node per cycle; the whole pipeline advances when the
// output register is empty or being taken.
// Reset: valid bits clear; configuration returns to its default values.
module mpm_grid_node_update #(
    parameter int GRID_SIZE = mpm_pkg::GRID_SIZE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mpm_pkg::node_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mpm_pkg::node_out_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import mpm_pkg::*;

    localparam int DEPTH = DIV_STAGES + 3 + 1;

    cfg_t  cfg_reg;
    logic  [DEPTH-1:0] vld_reg;
    logic  en;
    side_t side_in;
    side_t side_reg [DIV_STAGES];
    logic  [2:0] neg_reg [DIV_STAGES];
    logic  [47:0] qx, qy, qz;
    node_out_t res;
    node_out_t out_reg;

    assign en       = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_step   <= 16'd128;
            cfg_reg.wall_thickness <= 4'd2;
            cfg_reg.box_min_x      <= 15'd6554;
            cfg_reg.box_min_y      <= 15'd0;
            cfg_reg.box_min_z      <= 15'd6554;
            cfg_reg.box_max_x      <= 15'd8192;
            cfg_reg.box_max_y      <= 15'd3277;
            cfg_reg.box_max_z      <= 15'd8192;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAVITY: cfg_reg.gravity_step   <= cfg_data;
                CFG_WALL:    cfg_reg.wall_thickness <= cfg_data[3:0];
                CFG_MIN_X:   cfg_reg.box_min_x      <= cfg_data[14:0];
                CFG_MIN_Y:   cfg_reg.box_min_y      <= cfg_data[14:0];
                CFG_MIN_Z:   cfg_reg.box_min_z      <= cfg_data[14:0];
                CFG_MAX_X:   cfg_reg.box_max_x      <= cfg_data[14:0];
                CFG_MAX_Y:   cfg_reg.box_max_y      <= cfg_data[14:0];
                CFG_MAX_Z:   cfg_reg.box_max_z      <= cfg_data[14:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    function automatic logic [31:0] mag(input logic signed [31:0] m);
        mag = m[31] ? 32'(-m) : m;
    endfunction

    assign side_in = '{node_i: in_data.node_i, node_j: in_data.node_j,
                       node_k: in_data.node_k, active: in_data.node_mass != '0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            neg_reg[0]  <= {in_data.momentum_z[31], in_data.momentum_y[31],
                            in_data.momentum_x[31]};
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
            out_reg <= res;
        end
    end

    mpm_div u_div_x (.clk, .en, .dividend({mag(in_data.momentum_x), 16'b0}),
                     .divisor(in_data.node_mass), .quotient(qx));
    mpm_div u_div_y (.clk, .en, .dividend({mag(in_data.momentum_y), 16'b0}),
                     .divisor(in_data.node_mass), .quotient(qy));
    mpm_div u_div_z (.clk, .en, .dividend({mag(in_data.momentum_z), 16'b0}),
                     .divisor(in_data.node_mass), .quotient(qz));

    mpm_bc #(.GRID_SIZE(GRID_SIZE)) u_bc (
        .clk, .en, .cfg(cfg_reg), .side(side_reg[DIV_STAGES-1]),
        .neg(neg_reg[DIV_STAGES-1]), .qx, .qy, .qz, .result(res)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_inact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.node_active |-> out_data.vel_x == '0 &&
        out_data.vel_y == '0 && out_data.vel_z == '0)
        else $error("inactive node has velocity");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled while empty at output");

endmodule
`default_nettype wire
